// File: hdl/sic_pkg.sv
// Shared types and codes for the segment intersection classifier.
package sic_pkg;

  // Sign of one exact cross product.
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  typedef enum logic [2:0] {
    REL_MISS    = 3'd0,
    REL_CROSS   = 3'd1,
    REL_APART   = 3'd2,
    REL_TOUCH   = 3'd3,
    REL_OVERLAP = 3'd4
  } relation_t;

endpackage

// File: hdl/sic_cross.sv
// Two-stage exact sign of the cross product ux*vy - uy*vx.
module sic_cross #(
  parameter int W = 33
) (
  input  logic                clk,
  input  logic signed [W-1:0] ux,
  input  logic signed [W-1:0] uy,
  input  logic signed [W-1:0] vx,
  input  logic signed [W-1:0] vy,
  output sic_pkg::sign_t      sgn
);

  localparam int PW = 2 * W;

  logic signed [PW-1:0] m1;
  logic signed [PW-1:0] m2;
  logic        [PW:0]   diff;

  // Stage one: both products, registered.
  always_ff @(posedge clk) begin
    m1 <= ux * vy;
    m2 <= uy * vx;
  end

  // One guard bit keeps the difference exact.
  always_comb begin
    diff = {m1[PW-1], m1} - {m2[PW-1], m2};
  end

  // Stage two: sign and zero flag.
  always_ff @(posedge clk) begin
    sgn.neg  <= diff[PW];
    sgn.zero <= (diff == '0);
  end

endmodule

// File: hdl/segment_intersection_classifier.sv
// Top level: pipelined classifier for a pair of 2D integer line segments.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  request   | start / busy     | seg_a_start_x .. seg_b_end_y, 32 b signed
//  result    | done (strobe)    | relation_code, 3 b
//
//  One request is taken in every cycle; busy is tied low as nothing stalls.
//  Results leave in request order, after four registered stages: one
//  stage of differences and extents, two stages in each cross-product unit
//  (multiply, then subtract), one stage of classification.
//  Reset clears the valid bits only; done stays low until a request has
//  passed all four stages. The receiver cannot stall, so done is one cycle.
module segment_intersection_classifier #(
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] seg_a_start_x,
  input  logic signed [31:0] seg_a_start_y,
  input  logic signed [31:0] seg_a_end_x,
  input  logic signed [31:0] seg_a_end_y,
  input  logic signed [31:0] seg_b_start_x,
  input  logic signed [31:0] seg_b_start_y,
  input  logic signed [31:0] seg_b_end_x,
  input  logic signed [31:0] seg_b_end_y,
  output logic               done,
  output logic [2:0]         relation_code
);

  // Difference of two coordinates needs one extra bit.
  localparam int DW = COORD_BITS + 1;

  // Cross-product units.
  localparam int CR_DIR = 0;  // direction of A against direction of B
  localparam int CR_O1  = 1;  // turn A start -> A end -> B start
  localparam int CR_O2  = 2;  // turn A start -> A end -> B end
  localparam int CR_O3  = 3;  // turn B start -> B end -> A start
  localparam int CR_O4  = 4;  // turn B start -> B end -> A end
  localparam int CR_PAR = 5;  // collinearity test for parallel segments
  localparam int NCR    = 6;

  typedef struct packed {
    logic adeg;    // segment A is a point
    logic bdeg;    // segment B is a point
    logic pts_eq;  // both start points coincide
    logic use_x;   // compare extents along x, else along y
  } flags_t;

  function automatic logic signed [COORD_BITS-1:0] smin(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] smax(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  // Low COORD_BITS of each field, read as two's complement.
  logic signed [COORD_BITS-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

  assign ax1 = seg_a_start_x[COORD_BITS-1:0];
  assign ay1 = seg_a_start_y[COORD_BITS-1:0];
  assign ax2 = seg_a_end_x[COORD_BITS-1:0];
  assign ay2 = seg_a_end_y[COORD_BITS-1:0];
  assign bx1 = seg_b_start_x[COORD_BITS-1:0];
  assign by1 = seg_b_start_y[COORD_BITS-1:0];
  assign bx2 = seg_b_end_x[COORD_BITS-1:0];
  assign by2 = seg_b_end_y[COORD_BITS-1:0];

  // Never stall the request side.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: differences, degenerate flags, extents
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] adx, ady, bdx, bdy;
  logic signed [DW-1:0] b1a1x, b1a1y, a1b1x, a1b1y;
  logic                 adeg_c, bdeg_c;
  flags_t               flg_c;

  always_comb begin
    adx    = DW'(ax2) - DW'(ax1);
    ady    = DW'(ay2) - DW'(ay1);
    bdx    = DW'(bx2) - DW'(bx1);
    bdy    = DW'(by2) - DW'(by1);
    b1a1x  = DW'(bx1) - DW'(ax1);
    b1a1y  = DW'(by1) - DW'(ay1);
    a1b1x  = DW'(ax1) - DW'(bx1);
    a1b1y  = DW'(ay1) - DW'(by1);
    adeg_c = (ax1 == ax2) && (ay1 == ay2);
    bdeg_c = (bx1 == bx2) && (by1 == by2);
    flg_c.adeg   = adeg_c;
    flg_c.bdeg   = bdeg_c;
    flg_c.pts_eq = (ax1 == bx1) && (ay1 == by1);
    // Take the axis along which the reference segment moves.
    flg_c.use_x  = adeg_c ? (bx1 != bx2) : (ax1 != ax2);
  end

  logic                         v1;
  logic signed [DW-1:0]         s1_ux [NCR];
  logic signed [DW-1:0]         s1_uy [NCR];
  logic signed [DW-1:0]         s1_vx [NCR];
  logic signed [DW-1:0]         s1_vy [NCR];
  flags_t                       s1_flg;
  // Extents, index 0 along x and 1 along y.
  logic signed [COORD_BITS-1:0] s1_alo [2];
  logic signed [COORD_BITS-1:0] s1_ahi [2];
  logic signed [COORD_BITS-1:0] s1_blo [2];
  logic signed [COORD_BITS-1:0] s1_bhi [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ux[CR_DIR] <= adx;
    s1_uy[CR_DIR] <= ady;
    s1_vx[CR_DIR] <= bdx;
    s1_vy[CR_DIR] <= bdy;

    s1_ux[CR_O1] <= adx;
    s1_uy[CR_O1] <= ady;
    s1_vx[CR_O1] <= DW'(bx1) - DW'(ax2);
    s1_vy[CR_O1] <= DW'(by1) - DW'(ay2);

    s1_ux[CR_O2] <= adx;
    s1_uy[CR_O2] <= ady;
    s1_vx[CR_O2] <= DW'(bx2) - DW'(ax2);
    s1_vy[CR_O2] <= DW'(by2) - DW'(ay2);

    s1_ux[CR_O3] <= bdx;
    s1_uy[CR_O3] <= bdy;
    s1_vx[CR_O3] <= DW'(ax1) - DW'(bx2);
    s1_vy[CR_O3] <= DW'(ay1) - DW'(by2);

    s1_ux[CR_O4] <= bdx;
    s1_uy[CR_O4] <= bdy;
    s1_vx[CR_O4] <= DW'(ax2) - DW'(bx2);
    s1_vy[CR_O4] <= DW'(ay2) - DW'(by2);

    // Test the other segment's start against the line of the one that
    // is not a point.
    s1_ux[CR_PAR] <= adeg_c ? bdx : adx;
    s1_uy[CR_PAR] <= adeg_c ? bdy : ady;
    s1_vx[CR_PAR] <= adeg_c ? a1b1x : b1a1x;
    s1_vy[CR_PAR] <= adeg_c ? a1b1y : b1a1y;

    s1_flg <= flg_c;

    s1_alo[0] <= smin(ax1, ax2);
    s1_ahi[0] <= smax(ax1, ax2);
    s1_blo[0] <= smin(bx1, bx2);
    s1_bhi[0] <= smax(bx1, bx2);
    s1_alo[1] <= smin(ay1, ay2);
    s1_ahi[1] <= smax(ay1, ay2);
    s1_blo[1] <= smin(by1, by2);
    s1_bhi[1] <= smax(by1, by2);
  end

  // ---------------------------------------------------------------------
  // Stages 2 and 3: cross-product signs (two stages inside each unit)
  // ---------------------------------------------------------------------
  sic_pkg::sign_t crs [NCR];

  for (genvar gi = 0; gi < NCR; gi++) begin : g_cross
    sic_cross #(
      .W (DW)
    ) u_cross (
      .clk (clk),
      .ux  (s1_ux[gi]),
      .uy  (s1_uy[gi]),
      .vx  (s1_vx[gi]),
      .vy  (s1_vy[gi]),
      .sgn (crs[gi])
    );
  end

  // Extent overlap runs alongside: common stretch, then its length sign.
  logic                         v2, v3;
  flags_t                       s2_flg, s3_flg;
  logic signed [COORD_BITS-1:0] s2_lo [2];
  logic signed [COORD_BITS-1:0] s2_hi [2];
  logic                         s3_gt [2];
  logic                         s3_eq [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s2_flg <= s1_flg;
    s3_flg <= s2_flg;
    for (int k = 0; k < 2; k++) begin
      s2_lo[k] <= smax(s1_alo[k], s1_blo[k]);
      s2_hi[k] <= smin(s1_ahi[k], s1_bhi[k]);
      s3_gt[k] <= (s2_lo[k] > s2_hi[k]);
      s3_eq[k] <= (s2_lo[k] == s2_hi[k]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: classify and drive the result
  // ---------------------------------------------------------------------
  sic_pkg::relation_t code;
  logic               gap;
  logic               single;

  always_comb begin
    gap    = s3_flg.use_x ? s3_gt[0] : s3_gt[1];
    single = s3_flg.use_x ? s3_eq[0] : s3_eq[1];
    if (!crs[CR_DIR].zero) begin
      // Non-parallel: each segment must straddle or touch the other's line.
      code = ((crs[CR_O1] != crs[CR_O2]) && (crs[CR_O3] != crs[CR_O4]))
             ? sic_pkg::REL_CROSS : sic_pkg::REL_MISS;
    end else if (s3_flg.adeg && s3_flg.bdeg) begin
      code = s3_flg.pts_eq ? sic_pkg::REL_TOUCH : sic_pkg::REL_APART;
    end else if (!crs[CR_PAR].zero) begin
      // Distinct parallel lines.
      code = sic_pkg::REL_APART;
    end else if (gap) begin
      code = sic_pkg::REL_APART;
    end else if (single) begin
      code = sic_pkg::REL_TOUCH;
    end else begin
      code = sic_pkg::REL_OVERLAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    relation_code <= code;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result strobe without a request four cycles earlier");

  a_code_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (relation_code <= sic_pkg::REL_OVERLAP))
    else $error("relation code out of range");

  a_nonpar_class : assert property (@(posedge clk) disable iff (rst)
    (v3 && !crs[CR_DIR].zero) |=>
      ((relation_code == sic_pkg::REL_MISS) || (relation_code == sic_pkg::REL_CROSS)))
    else $error("non-parallel pair given a parallel class");

endmodule

// File: bench/tb_segment_intersection_classifier.sv
// Self-checking bench for the segment intersection classifier: directed and random requests.
`timescale 1ns / 1ps

module tb_segment_intersection_classifier;

  localparam int COORD_BITS = 32;
  localparam int RANDOM_REQUESTS = 1500;
  // Four pipeline stages; this drain runs after the last result, before the verdict.
  localparam int DRAIN_CYCLES = 8;
  // Request counts at which the sender's idling pattern changes.
  localparam int PHASE_ONE_END = 500;
  localparam int PHASE_TWO_END = 1000;
  localparam longint C_MIN = -64'sd2147483648;
  localparam longint C_MAX = 64'sd2147483647;

  typedef logic signed [67:0] wide_t;

  // One request: both segments, raw 32-bit port values.
  typedef struct {
    logic [31:0] a_sx, a_sy, a_ex, a_ey;
    logic [31:0] b_sx, b_sy, b_ex, b_ey;
  } seg_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] seg_a_start_x = '0;
  logic [31:0] seg_a_start_y = '0;
  logic [31:0] seg_a_end_x = '0;
  logic [31:0] seg_a_end_y = '0;
  logic [31:0] seg_b_start_x = '0;
  logic [31:0] seg_b_start_y = '0;
  logic [31:0] seg_b_end_x = '0;
  logic [31:0] seg_b_end_y = '0;
  logic        done;
  logic [2:0]  relation_code;

  seg_pair_t           queued_pairs[$];       // requests not yet presented
  sic_pkg::relation_t  pending_relations[$];  // classes owed by the block, oldest first
  int                  accepted_count = 0;
  int                  total_requests = 0;
  int                  errors = 0;

  segment_intersection_classifier #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .seg_a_start_x(seg_a_start_x),
    .seg_a_start_y(seg_a_start_y),
    .seg_a_end_x(seg_a_end_x),
    .seg_a_end_y(seg_a_end_y),
    .seg_b_start_x(seg_b_start_x),
    .seg_b_start_y(seg_b_start_y),
    .seg_b_end_x(seg_b_end_x),
    .seg_b_end_y(seg_b_end_y),
    .done(done),
    .relation_code(relation_code)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Keep the low COORD_BITS bits of a port value and sign-extend them.
  function automatic longint to_coord(logic [31:0] v);
    logic [63:0] t;
    t = {{(64 - COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]};
    return longint'(t);
  endfunction

  // Sign of ux*vy - uy*vx, worked out at full width so nothing wraps.
  function automatic int cross_dir(longint ux, longint uy, longint vx, longint vy);
    wide_t a, b, c, d, p;
    a = ux;
    b = uy;
    c = vx;
    d = vy;
    p = a * d - b * c;
    if (p == 0) return 0;
    return (p < 0) ? -1 : 1;
  endfunction

  // Turn direction p -> q -> r.
  function automatic int turn(longint px, longint py, longint qx, longint qy,
                              longint rx, longint ry);
    return cross_dir(qx - px, qy - py, rx - qx, ry - qy);
  endfunction

  function automatic sic_pkg::relation_t segment_relation(seg_pair_t s);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    longint adx, ady, bdx, bdy, alo, ahi, blo, bhi, lo, hi;
    bit     adeg, bdeg, along_x;
    ax1 = to_coord(s.a_sx);
    ay1 = to_coord(s.a_sy);
    ax2 = to_coord(s.a_ex);
    ay2 = to_coord(s.a_ey);
    bx1 = to_coord(s.b_sx);
    by1 = to_coord(s.b_sy);
    bx2 = to_coord(s.b_ex);
    by2 = to_coord(s.b_ey);
    adx = ax2 - ax1;
    ady = ay2 - ay1;
    bdx = bx2 - bx1;
    bdy = by2 - by1;
    adeg = (adx == 0) && (ady == 0);
    bdeg = (bdx == 0) && (bdy == 0);

    // Non-parallel: each segment must straddle or touch the other's line.
    if (cross_dir(adx, ady, bdx, bdy) != 0) begin
      if (turn(ax1, ay1, ax2, ay2, bx1, by1) != turn(ax1, ay1, ax2, ay2, bx2, by2) &&
          turn(bx1, by1, bx2, by2, ax1, ay1) != turn(bx1, by1, bx2, by2, ax2, ay2))
        return sic_pkg::REL_CROSS;
      return sic_pkg::REL_MISS;
    end

    // Two points: equal or not.
    if (adeg && bdeg)
      return (ax1 == bx1 && ay1 == by1) ? sic_pkg::REL_TOUCH : sic_pkg::REL_APART;

    // Take the non-degenerate segment as the reference line.
    if (!adeg) begin
      if (cross_dir(adx, ady, bx1 - ax1, by1 - ay1) != 0) return sic_pkg::REL_APART;
      along_x = (adx != 0);
    end else begin
      if (cross_dir(bdx, bdy, ax1 - bx1, ay1 - by1) != 0) return sic_pkg::REL_APART;
      along_x = (bdx != 0);
    end

    // Collinear: intersect the extents along one axis.
    if (along_x) begin
      alo = (ax1 < ax2) ? ax1 : ax2;
      ahi = (ax1 > ax2) ? ax1 : ax2;
      blo = (bx1 < bx2) ? bx1 : bx2;
      bhi = (bx1 > bx2) ? bx1 : bx2;
    end else begin
      alo = (ay1 < ay2) ? ay1 : ay2;
      ahi = (ay1 > ay2) ? ay1 : ay2;
      blo = (by1 < by2) ? by1 : by2;
      bhi = (by1 > by2) ? by1 : by2;
    end
    lo = (alo > blo) ? alo : blo;
    hi = (ahi < bhi) ? ahi : bhi;
    if (lo > hi) return sic_pkg::REL_APART;
    if (lo == hi) return sic_pkg::REL_TOUCH;
    return sic_pkg::REL_OVERLAP;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic seg_pair_t pair_of(longint c[8]);
    seg_pair_t s;
    s.a_sx = 32'(c[0]);
    s.a_sy = 32'(c[1]);
    s.a_ex = 32'(c[2]);
    s.a_ey = 32'(c[3]);
    s.b_sx = 32'(c[4]);
    s.b_sy = 32'(c[5]);
    s.b_ex = 32'(c[6]);
    s.b_ey = 32'(c[7]);
    return s;
  endfunction

  function automatic void queue_request(longint ax1, longint ay1, longint ax2, longint ay2,
                                        longint bx1, longint by1, longint bx2, longint by2);
    queued_pairs.push_back(pair_of('{ax1, ay1, ax2, ay2, bx1, by1, bx2, by2}));
  endfunction

  // Uniform in [-r, r]; r stays well below 2^31.
  function automatic longint signed_pick(longint r);
    return longint'($urandom_range(0, 32'(2 * r))) - r;
  endfunction

  function automatic longint corner_value();
    case ($urandom_range(0, 6))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      5:       return C_MIN + 1;
      default: return C_MAX - 1;
    endcase
  endfunction

  // Mix of shapes: half of the requests are built to land on parallel, collinear,
  // shared-endpoint and degenerate cases; the rest are noise (raw or small) and corners.
  function automatic seg_pair_t random_pair();
    longint      c[8];
    longint      span, px, py, dx, dy, step, ox, oy, t, tmp;
    int unsigned kind, j;
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 1) != 0) ? 64'sd4 : (64'sd1 << 27);
    step = 64'sd1 << $urandom_range(0, 20);
    px = signed_pick(span);
    py = signed_pick(span);
    dx = signed_pick(step);
    dy = signed_pick(step);
    ox = 0;
    oy = 0;
    if (kind < 20) begin
      foreach (c[i]) c[i] = $urandom;
    end else if (kind < 40) begin
      foreach (c[i]) c[i] = signed_pick(4);
    end else if (kind < 78) begin
      // Points on one line; shift B off it for the parallel-distinct share.
      if (kind >= 65) begin
        ox = signed_pick(span);
        oy = signed_pick(span);
      end
      for (int i = 0; i < 4; i++) begin
        t = signed_pick(3);
        c[2*i]   = px + t * dx + ((i >= 2) ? ox : 0);
        c[2*i+1] = py + t * dy + ((i >= 2) ? oy : 0);
      end
    end else if (kind < 90) begin
      // B starts on an endpoint of A, and is sometimes just that point.
      for (int i = 0; i < 4; i++) c[i] = signed_pick(span);
      j = $urandom_range(0, 1) * 2;
      c[4] = c[j];
      c[5] = c[j+1];
      if ($urandom_range(0, 3) == 0) begin
        c[6] = c[4];
        c[7] = c[5];
      end else begin
        c[6] = signed_pick(span);
        c[7] = signed_pick(span);
      end
    end else begin
      foreach (c[i]) c[i] = corner_value();
    end
    // Swap the roles of A and B half of the time.
    if ($urandom_range(0, 1) != 0) begin
      for (int i = 0; i < 4; i++) begin
        tmp    = c[i];
        c[i]   = c[i+4];
        c[i+4] = tmp;
      end
    end
    return pair_of(c);
  endfunction

  // Sender idling: moderate, then heavy, then none.
  function automatic int idle_share(int n);
    if (n < PHASE_ONE_END) return 15;
    if (n < PHASE_TWO_END) return 70;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued requests, record the expected class on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    seg_pair_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      // A request moves on this edge: predict it from what is on the ports.
      if (start && !busy) begin
        pending_relations.push_back(segment_relation('{seg_a_start_x, seg_a_start_y,
                                                       seg_a_end_x, seg_a_end_y,
                                                       seg_b_start_x, seg_b_start_y,
                                                       seg_b_end_x, seg_b_end_y}));
        accepted_count++;
      end
      // Hold a request the block has not taken; otherwise advance or idle.
      if (!(start && busy)) begin
        if (queued_pairs.size() != 0 &&
            $urandom_range(0, 99) >= idle_share(accepted_count)) begin
          nxt = queued_pairs.pop_front();
          seg_a_start_x <= nxt.a_sx;
          seg_a_start_y <= nxt.a_sy;
          seg_a_end_x   <= nxt.a_ex;
          seg_a_end_y   <= nxt.a_ey;
          seg_b_start_x <= nxt.b_sx;
          seg_b_start_y <= nxt.b_sy;
          seg_b_end_x   <= nxt.b_ex;
          seg_b_end_y   <= nxt.b_ey;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobed result is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sic_pkg::relation_t want;
    if (!rst && done === 1'b1) begin
      if (pending_relations.size() == 0) begin
        $display("%0t unexpected result: expected none, actual relation_code=%0d",
                 $time, relation_code);
        errors++;
      end else begin
        want = pending_relations.pop_front();
        if (relation_code !== want) begin
          $display("%0t relation_code mismatch: expected %0d (%s), actual %0d",
                   $time, want, want.name(), relation_code);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the request queue, release reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    // Non-parallel: crossing, clean miss, T-junction at an endpoint, near T.
    queue_request(0, 0, 10, 10, 0, 10, 10, 0);
    queue_request(0, 0, 1, 1, 5, 0, 6, -3);
    queue_request(0, 0, 4, 0, 4, 0, 4, 5);
    queue_request(0, 0, 4, 0, 2, -3, 2, -1);
    // Distinct parallel lines.
    queue_request(0, 0, 4, 0, 0, 1, 4, 1);
    // Collinear along x: apart, single shared point, overlap.
    queue_request(0, 0, 2, 0, 3, 0, 5, 0);
    queue_request(0, 0, 2, 0, 2, 0, 5, 0);
    queue_request(0, 0, 4, 0, 2, 0, 6, 0);
    // Identical and reversed segments.
    queue_request(1, 2, 7, 5, 1, 2, 7, 5);
    queue_request(1, 2, 7, 5, 7, 5, 1, 2);
    // Containment either way round.
    queue_request(2, 2, 3, 3, 0, 0, 5, 5);
    queue_request(0, 0, 5, 5, 2, 2, 3, 3);
    // Vertical collinear: extents taken along y.
    queue_request(1, 0, 1, 5, 1, 5, 1, 9);
    queue_request(1, 0, 1, 5, 1, 9, 1, 3);
    queue_request(1, 0, 1, 5, 1, 6, 1, 9);
    // Degenerate segments: point on and off the other, at an endpoint.
    queue_request(3, 3, 3, 3, 0, 0, 6, 6);
    queue_request(3, 4, 3, 4, 0, 0, 6, 6);
    queue_request(0, 0, 6, 6, 6, 6, 6, 6);
    // Both degenerate: equal and distinct points.
    queue_request(5, 5, 5, 5, 5, 5, 5, 5);
    queue_request(5, 5, 5, 5, 5, 6, 5, 6);
    // Field extremes, where the products need the full width.
    queue_request(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
    queue_request(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN + 1, C_MAX, C_MAX);
    queue_request(C_MIN, 0, C_MAX, 0, C_MAX, 0, C_MAX, 0);
    queue_request(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN);
    queue_request(C_MAX, C_MIN, C_MIN, C_MAX, 0, -1, -1, 0);
    queue_request(-1, -1, -1, -1, C_MAX, C_MAX, C_MIN, C_MIN);

    for (int i = 0; i < RANDOM_REQUESTS; i++) queued_pairs.push_back(random_pair());
    total_requests = queued_pairs.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last request to be taken, then for its result.
    while (accepted_count < total_requests) @(posedge clk);
    while (pending_relations.size() != 0) @(posedge clk);
    // Leave room for any stray strobe to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[segment_intersection_classifier] OK");
    end else begin
      $display("[segment_intersection_classifier] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("[segment_intersection_classifier] ERROR");
    $finish;
  end

endmodule
